### sv/deadline_ordered_timer_queue_assert.svh
// Assertion macros for the deadline ordered timer queue.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DOTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DOTQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DOTQ_ASSERT_IMP(lbl, ante, cons, msg)
`define DOTQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### sv/dotq_pkg.sv
// Shared constants and command codes for the deadline ordered timer queue.
// No dependencies.
package dotq_pkg;
	localparam int ALARM_SLOTS_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int MAX_RES_W       = $clog2(MAX_RESULTS + 1);
	localparam int FIRED_IDX_W     = $clog2(MAX_RESULTS);
	localparam int ID_W            = 4;
	localparam int TIME_W          = 63;
	localparam int CMD_W           = 3;

	localparam logic [CMD_W-1:0] CMD_ARM    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIRE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
endpackage

### sv/deadline_ordered_timer_queue.sv
// Deadline ordered timer queue: one command beat in, one or more result beats out.
// Arm and update walk the sorted order list: for each entry passed, a deadline RAM read,
// then the shared comparator. Update of an armed alarm first searches for it; cancel
// searches for the alarm and unlinks it. Fire pops expired alarms from the head, each
// with a read and a compare; clear drops every alarm. Result beats then leave at one per
// cycle while out_ready is high. The deadline RAM has a single read port; one comparator.
// Depends on dotq_pkg, dotq_ram and deadline_ordered_timer_queue_assert.svh.
`include "deadline_ordered_timer_queue_assert.svh"

module deadline_ordered_timer_queue import dotq_pkg::*; #(
	parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  command,
	input  logic [ID_W-1:0]   alarm_id,
	input  logic [TIME_W-1:0] time_us,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              fired_valid,
	output logic [ID_W-1:0]   fired_alarm,
	output logic [TIME_W-1:0] next_deadline,
	output logic              last
);
	localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int CNT_W  = $clog2(ALARM_SLOTS + 1);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_DECODE   = 10'b0000000010,
		S_UNLINK   = 10'b0000000100,
		S_SCAN_RD  = 10'b0000001000,
		S_SCAN_CMP = 10'b0000010000,
		S_FIRE_RD  = 10'b0000100000,
		S_FIRE_CMP = 10'b0001000000,
		S_HEAD_RD  = 10'b0010000000,
		S_HEAD_CMP = 10'b0100000000,
		S_EMIT     = 10'b1000000000
	} state_t;

	state_t                 state_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [ID_W-1:0]        id_q;
	logic [TIME_W-1:0]      t_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [ALARM_SLOTS-1:0] armed_q;
	logic [ID_W-1:0]        order_q [ALARM_SLOTS];
	logic [ID_W-1:0]        fired_q [MAX_RESULTS];
	logic [MAX_RES_W-1:0]   nf_q;
	logic [MAX_RES_W-1:0]   k_q;
	logic                   out_valid_q;
	logic                   fired_valid_q;
	logic [ID_W-1:0]        fired_alarm_q;
	logic [TIME_W-1:0]      next_q;
	logic                   last_q;

	logic              id_ok;
	logic              id_armed;
	logic [ID_W-1:0]   ord_at_idx;
	logic [ID_W-1:0]   head_id;
	logic              rd_gt;
	logic              do_insert;
	logic [SLOT_W-1:0] ram_raddr;
	logic [TIME_W-1:0] rd_data;

	assign id_ok      = 32'(id_q) < ALARM_SLOTS;
	assign id_armed   = armed_q[SLOT_W'(id_q)];
	assign ord_at_idx = order_q[idx_q[SLOT_W-1:0]];
	assign head_id    = order_q[0];
	assign rd_gt      = rd_data > t_q;
	assign do_insert  = ((state_q == S_SCAN_RD) && (idx_q == count_q)) ||
		((state_q == S_SCAN_CMP) && rd_gt);

	always_comb begin
		if (state_q == S_SCAN_RD) begin
			ram_raddr = SLOT_W'(ord_at_idx);
		end else begin
			ram_raddr = SLOT_W'(head_id);
		end
	end

	dotq_ram #(
		.WIDTH (TIME_W),
		.DEPTH (ALARM_SLOTS)
	) u_deadline_ram (
		.clk     (clk),
		.wr_en   (do_insert),
		.wr_addr (SLOT_W'(id_q)),
		.wr_data (t_q),
		.rd_addr (ram_raddr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			armed_q     <= '0;
			idx_q       <= '0;
			nf_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						id_q    <= alarm_id;
						t_q     <= time_us;
						idx_q   <= '0;
						nf_q    <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					priority if (cmd_q == CMD_ARM) begin
						if (id_ok && !id_armed && (count_q < CNT_W'(ALARM_SLOTS))) begin
							state_q <= S_SCAN_RD;
						end else begin
							state_q <= S_HEAD_RD;
						end
					end else if (cmd_q == CMD_UPDATE) begin
						priority if (!id_ok) begin
							state_q <= S_HEAD_RD;
						end else if (id_armed) begin
							state_q <= S_UNLINK;
						end else if (count_q < CNT_W'(ALARM_SLOTS)) begin
							state_q <= S_SCAN_RD;
						end else begin
							state_q <= S_HEAD_RD;
						end
					end else if (cmd_q == CMD_CANCEL) begin
						state_q <= (id_ok && id_armed) ? S_UNLINK : S_HEAD_RD;
					end else if (cmd_q == CMD_FIRE) begin
						state_q <= (t_q != '0) ? S_FIRE_RD : S_HEAD_RD;
					end else if (cmd_q == CMD_CLEAR) begin
						armed_q <= '0;
						count_q <= '0;
						state_q <= S_HEAD_RD;
					end else begin
						state_q <= S_HEAD_RD;
					end
				end
				S_UNLINK: begin
					priority if (idx_q >= count_q) begin
						armed_q[SLOT_W'(id_q)] <= 1'b0;
						idx_q   <= '0;
						state_q <= (cmd_q == CMD_UPDATE) ? S_SCAN_RD : S_HEAD_RD;
					end else if (ord_at_idx == id_q) begin
						for (int j = 0; j < ALARM_SLOTS - 1; j++) begin
							if (CNT_W'(j) >= idx_q) begin
								order_q[j] <= order_q[j + 1];
							end
						end
						count_q <= count_q - CNT_W'(1);
						armed_q[SLOT_W'(id_q)] <= 1'b0;
						idx_q   <= '0;
						state_q <= (cmd_q == CMD_UPDATE) ? S_SCAN_RD : S_HEAD_RD;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_SCAN_RD, S_SCAN_CMP: begin
					if (do_insert) begin
						for (int j = 1; j < ALARM_SLOTS; j++) begin
							if (CNT_W'(j) > idx_q) begin
								order_q[j] <= order_q[j - 1];
							end
						end
						for (int j = 0; j < ALARM_SLOTS; j++) begin
							if (CNT_W'(j) == idx_q) begin
								order_q[j] <= id_q;
							end
						end
						armed_q[SLOT_W'(id_q)] <= 1'b1;
						count_q <= count_q + CNT_W'(1);
						state_q <= S_HEAD_RD;
					end else if (state_q == S_SCAN_RD) begin
						state_q <= S_SCAN_CMP;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_FIRE_RD: begin
					if ((count_q == '0) || (nf_q == MAX_RES_W'(MAX_RESULTS))) begin
						state_q <= S_HEAD_RD;
					end else begin
						state_q <= S_FIRE_CMP;
					end
				end
				S_FIRE_CMP: begin
					if (rd_gt) begin
						state_q <= S_HEAD_RD;
					end else begin
						for (int j = 0; j < ALARM_SLOTS - 1; j++) begin
							order_q[j] <= order_q[j + 1];
						end
						count_q <= count_q - CNT_W'(1);
						armed_q[SLOT_W'(head_id)] <= 1'b0;
						fired_q[nf_q[FIRED_IDX_W-1:0]] <= head_id;
						nf_q    <= nf_q + MAX_RES_W'(1);
						state_q <= S_FIRE_RD;
					end
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_CMP;
				end
				S_HEAD_CMP: begin
					next_q        <= (count_q != '0) ? rd_data : '0;
					fired_valid_q <= nf_q != '0;
					fired_alarm_q <= (nf_q != '0) ? fired_q[0] : '0;
					last_q        <= nf_q <= MAX_RES_W'(1);
					k_q           <= MAX_RES_W'(1);
					out_valid_q   <= 1'b1;
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							fired_alarm_q <= fired_q[k_q[FIRED_IDX_W-1:0]];
							last_q        <= (k_q + MAX_RES_W'(1)) == nf_q;
							k_q           <= k_q + MAX_RES_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = out_valid_q;
	assign fired_valid   = fired_valid_q;
	assign fired_alarm   = fired_alarm_q;
	assign next_deadline = next_q;
	assign last          = last_q;

	`DOTQ_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "result beat pending while idle")
	`DOTQ_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after accept")
	`DOTQ_ASSERT_IMP(a_empty_single, out_valid && !fired_valid, last, "empty result not last")
	`DOTQ_ASSERT_IMP(a_count_match, in_ready, 32'(count_q) == $countones(armed_q),
		"armed count disagrees with armed flags")
	`DOTQ_ASSERT_IMP(a_count_range, 1'b1, 32'(count_q) <= ALARM_SLOTS, "armed count overflow")
endmodule

### sv/dotq_ram.sv
// Generic single write, single read RAM with registered read data.
// Depends on dotq_pkg for default sizes.
module dotq_ram import dotq_pkg::*; #(
	parameter int WIDTH = TIME_W,
	parameter int DEPTH = ALARM_SLOTS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

### dv/deadline_ordered_timer_queue_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for deadline_ordered_timer_queue: directed and random commands,
// a behavioural alarm list predicting every result beat, random idling on both channels.
// Depends on dotq_pkg and the deadline_ordered_timer_queue RTL.
module deadline_ordered_timer_queue_tb;
	import dotq_pkg::*;

	localparam int          PHASE_ITEMS = 74;
	localparam int          DRAIN_CYCLES = 64;
	localparam logic [TIME_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] t;
	} dotq_cmd_beat_t;

	typedef struct packed {
		logic              fired_valid;
		logic [ID_W-1:0]   fired_alarm;
		logic [TIME_W-1:0] next_deadline;
		logic              last;
	} dotq_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  command = '0;
	logic [ID_W-1:0]   alarm_id = '0;
	logic [TIME_W-1:0] time_us = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              fired_valid;
	logic [ID_W-1:0]   fired_alarm;
	logic [TIME_W-1:0] next_deadline;
	logic              last;

	dotq_cmd_beat_t    cmd_backlog [$];
	dotq_result_t      predicted [$];
	int unsigned       send_idle_pct = 0;
	int unsigned       stall_pct = 0;
	int unsigned       mismatches = 0;

	// predictor state
	logic [TIME_W-1:0] due_at [ALARM_SLOTS_DEF];
	bit                armed [ALARM_SLOTS_DEF];
	logic [ID_W-1:0]   alarm_order [$];

	deadline_ordered_timer_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.alarm_id      (alarm_id),
		.time_us       (time_us),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fired_valid   (fired_valid),
		.fired_alarm   (fired_alarm),
		.next_deadline (next_deadline),
		.last          (last)
	);

	always #6 clk = ~clk;

	task automatic unlink_alarm(input logic [ID_W-1:0] id);
		foreach (alarm_order[p]) begin
			if (alarm_order[p] == id) begin
				alarm_order.delete(p);
				break;
			end
		end
		armed[id] = 1'b0;
	endtask

	task automatic link_alarm(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t);
		int pos;
		if (alarm_order.size() >= ALARM_SLOTS_DEF)
			return;
		pos = alarm_order.size();
		for (int i = 0; i < alarm_order.size(); i++) begin
			if (due_at[alarm_order[i]] > t) begin
				pos = i;
				break;
			end
		end
		alarm_order.insert(pos, id);
		due_at[id] = t;
		armed[id] = 1'b1;
	endtask

	task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] t);
		logic [ID_W-1:0]   fired [$];
		logic [ID_W-1:0]   head;
		logic [TIME_W-1:0] soonest;
		dotq_result_t      res;
		unique case (cmd)
		CMD_ARM: begin
			if (!armed[id])
				link_alarm(id, t);
		end
		CMD_UPDATE: begin
			if (armed[id])
				unlink_alarm(id);
			link_alarm(id, t);
		end
		CMD_CANCEL: begin
			if (armed[id])
				unlink_alarm(id);
		end
		CMD_FIRE: begin
			if (t != '0) begin
				while (alarm_order.size() > 0 && fired.size() < MAX_RESULTS &&
						due_at[alarm_order[0]] <= t) begin
					head = alarm_order[0];
					unlink_alarm(head);
					fired.push_back(head);
				end
			end
		end
		CMD_CLEAR: begin
			armed = '{default: 1'b0};
			alarm_order.delete();
		end
		default: begin
		end
		endcase
		soonest = alarm_order.size() > 0 ? due_at[alarm_order[0]] : '0;
		if (fired.size() == 0) begin
			res = '{1'b0, '0, soonest, 1'b1};
			predicted.push_back(res);
		end else begin
			foreach (fired[k]) begin
				res = '{1'b1, fired[k], soonest, k == fired.size() - 1};
				predicted.push_back(res);
			end
		end
	endtask

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] t);
		dotq_cmd_beat_t beat;
		beat = '{cmd, id, t};
		cmd_backlog.push_back(beat);
	endtask

	function automatic logic [TIME_W-1:0] pick_deadline(input logic [TIME_W-1:0] now_us);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 10)
			return T_MAX;
		if (r < 16)
			return TIME_W'({$urandom, $urandom});
		return now_us + TIME_W'($urandom_range(40));
	endfunction

	task automatic flag_mismatch(input string what, input dotq_result_t want,
			input dotq_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected valid %0b alarm %0d next %0d last %0b, actual valid %0b %s",
				what, want.fired_valid, want.fired_alarm, want.next_deadline, want.last,
				got.fired_valid, $sformatf("alarm %0d next %0d last %0b",
				got.fired_alarm, got.next_deadline, got.last));
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		dotq_cmd_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				apply_command(command, alarm_id, time_us);
			if (!(in_valid && !in_ready)) begin
				if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					command <= nxt.cmd;
					alarm_id <= nxt.id;
					time_us <= nxt.t;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= $urandom_range(99) >= stall_pct;
		end
	end

	// result monitor
	always @(posedge clk) begin
		dotq_result_t want;
		dotq_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{fired_valid, fired_alarm, next_deadline, last};
			if (predicted.size() == 0) begin
				flag_mismatch("result beat with nothing expected", '0, got);
			end else begin
				want = predicted.pop_front();
				if (want !== got)
					flag_mismatch("result mismatch", want, got);
			end
		end
	end

	initial begin
		int unsigned       send_idle_by_phase [4];
		int unsigned       stall_by_phase [4];
		int                counted;
		int unsigned       r;
		int unsigned       q;
		logic [TIME_W-1:0] now_us;
		send_idle_by_phase = '{0, 53, 0, 32};
		stall_by_phase = '{0, 0, 53, 32};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		now_us = '0;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_idle_by_phase[phase];
			stall_pct = stall_by_phase[phase];
			if (phase == 0) begin
				// zero deadline, duplicate arm, idle cancel, zero-time fire
				queue_cmd(CMD_CLEAR, '0, '0);
				queue_cmd(CMD_ARM, 4'd0, '0);
				queue_cmd(CMD_ARM, 4'd0, 63'd5);
				queue_cmd(CMD_CANCEL, 4'd3, '0);
				queue_cmd(CMD_FIRE, 4'd15, '0);
				queue_cmd(CMD_FIRE, '0, 63'd1);
				queue_cmd(CMD_W'((1 << CMD_W) - 1), 4'd15, T_MAX);
				// equal deadlines, update of idle and armed alarms
				queue_cmd(CMD_ARM, 4'd15, T_MAX);
				queue_cmd(CMD_UPDATE, 4'd15, 63'd100);
				queue_cmd(CMD_UPDATE, 4'd9, 63'd100);
				queue_cmd(CMD_ARM, 4'd3, 63'd100);
				queue_cmd(CMD_UPDATE, 4'd15, 63'd100);
				queue_cmd(CMD_CANCEL, 4'd9, '0);
				queue_cmd(CMD_FIRE, '0, 63'd99);
				queue_cmd(CMD_FIRE, '0, 63'd100);
				// full queue popped by one fire
				for (int i = 0; i < ALARM_SLOTS_DEF; i++)
					queue_cmd(CMD_ARM, ID_W'(i),
						(i == ALARM_SLOTS_DEF - 1) ? T_MAX : TIME_W'((i % 4) * 10));
				queue_cmd(CMD_FIRE, '0, T_MAX);
				queue_cmd(CMD_ARM, 4'd5, 63'd7);
				queue_cmd(CMD_CLEAR, '0, '0);
			end
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 30) begin
					queue_cmd(CMD_ARM, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)),
						pick_deadline(now_us));
				end else if (r < 50) begin
					queue_cmd(CMD_UPDATE, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)),
						pick_deadline(now_us));
				end else if (r < 62) begin
					queue_cmd(CMD_CANCEL, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)),
						TIME_W'({$urandom, $urandom}));
				end else if (r < 90) begin
					q = $urandom_range(19);
					if (q == 0)
						queue_cmd(CMD_FIRE, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)), '0);
					else if (q == 1)
						queue_cmd(CMD_FIRE, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)),
							T_MAX);
					else if (q == 2)
						queue_cmd(CMD_FIRE, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)),
							TIME_W'({$urandom, $urandom}));
					else begin
						now_us += TIME_W'($urandom_range(12));
						queue_cmd(CMD_FIRE, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)),
							now_us);
					end
				end else if (r < 93) begin
					queue_cmd(CMD_CLEAR, ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)), now_us);
				end else begin
					queue_cmd(CMD_W'($urandom_range(CMD_CLEAR + 1, (1 << CMD_W) - 1)),
						ID_W'($urandom_range(ALARM_SLOTS_DEF - 1)),
						TIME_W'({$urandom, $urandom}));
				end
				counted++;
			end
			while (cmd_backlog.size() != 0 || in_valid || predicted.size() != 0)
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && predicted.size() == 0)
			$display("deadline_ordered_timer_queue test passed");
		else
			$display("deadline_ordered_timer_queue test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("deadline_ordered_timer_queue test failed");
		$finish;
	end
endmodule
